[rtl/cddc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cddc_pkg
// Shared types and constants for the click, double-click and drag classifier.
// ----------------------------------------------------------------------------
package cddc_pkg;

    localparam int unsigned DT_W     = 20;
    localparam int unsigned POS_W    = 16;
    localparam int unsigned MOVE_W   = 17;
    localparam int unsigned TRAVEL_W = 18;
    localparam int unsigned TIMER_W  = 32;
    localparam int unsigned CFG_W    = 32;
    localparam int unsigned SQ_W     = 36;
    localparam int unsigned ADDR_W   = 4;

    localparam logic [CFG_W-1:0] HOLD_LIMIT_RST = 32'd200000;
    localparam logic [CFG_W-1:0] GAP_LIMIT_RST  = 32'd100000;
    localparam logic [CFG_W-1:0] DRAG_DIST_RST  = 32'd9;
    localparam logic [CFG_W-1:0] GAP_DIST_RST   = 32'd1;

    typedef enum logic [1:0] {
        G_NONE   = 2'd0,
        G_CLICK  = 2'd1,
        G_DOUBLE = 2'd2,
        G_DRAG   = 2'd3
    } t_gesture;

    typedef enum logic [5:0] {
        PH_START       = 6'b000001,
        PH_FIRST_DOWN  = 6'b000010,
        PH_FIRST_UP    = 6'b000100,
        PH_SECOND_DOWN = 6'b001000,
        PH_SECOND_UP   = 6'b010000,
        PH_END         = 6'b100000
    } t_phase;

    typedef enum logic [1:0] {
        REG_HOLD_LIMIT = 2'd0,
        REG_GAP_LIMIT  = 2'd1,
        REG_DRAG_DIST  = 2'd2,
        REG_GAP_DIST   = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [CFG_W-1:0] hold_limit_us;
        logic [CFG_W-1:0] gap_limit_us;
        logic [CFG_W-1:0] drag_dist_sq;
        logic [CFG_W-1:0] gap_dist_sq;
    } t_cfg;

    // One registered tick, with the pointer move already formed.
    typedef struct packed {
        logic [DT_W-1:0]          elapsed_us;
        logic                     button_down;
        logic signed [MOVE_W-1:0] move_x;
        logic signed [MOVE_W-1:0] move_y;
    } t_tick;

endpackage
`default_nettype wire

[rtl/cddc_in_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cddc_in_if
// Input channel: one sampling tick per item.
// ----------------------------------------------------------------------------
interface cddc_in_if;
    logic               valid;
    logic               ready;
    logic [19:0]        elapsed_us;
    logic               button_down;
    logic signed [15:0] pointer_x;
    logic signed [15:0] pointer_y;

    modport source (
        output valid, elapsed_us, button_down, pointer_x, pointer_y,
        input  ready
    );
    modport sink (
        input  valid, elapsed_us, button_down, pointer_x, pointer_y,
        output ready
    );
endinterface
`default_nettype wire

[rtl/cddc_out_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cddc_out_if
// Output channel: one gesture code and pointer move per item.
// ----------------------------------------------------------------------------
interface cddc_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         gesture;
    logic signed [16:0] move_x;
    logic signed [16:0] move_y;

    modport source (
        output valid, gesture, move_x, move_y,
        input  ready
    );
    modport sink (
        input  valid, gesture, move_x, move_y,
        output ready
    );
endinterface
`default_nettype wire

[rtl/click_doubleclick_drag_classifier.sv]
`default_nettype none
// An accepted item is held in the input register; its result is then registered in the
// result register, which presents it on the output channel.
// Throughput: one item per cycle while the output is not stalled; the gesture state,
// timer and travel update combinationally between the two registers.
// Reset (synchronous, active low) returns the machine to the start phase,
// clears timer, travel and last position, and restores the default limits.
// ----------------------------------------------------------------------------
// click_doubleclick_drag_classifier
// Classifies pointer button activity into click, double click and drag and
// reports the pointer move of every tick.
// ----------------------------------------------------------------------------
module click_doubleclick_drag_classifier
    import cddc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    cddc_in_if.sink                i_in,
    cddc_out_if.source             o_out,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [CFG_W-1:0]  pwdata,
    output logic      [CFG_W-1:0]  prdata,
    output logic                   pready
);

    t_cfg  cfg;
    t_tick tick;
    logic  tick_valid;
    logic  tick_take;

    cddc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    cddc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_take  (tick_take),
        .o_valid (tick_valid),
        .o_tick  (tick)
    );

    cddc_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (tick_valid),
        .i_tick  (tick),
        .i_cfg   (cfg),
        .o_take  (tick_take),
        .o_out   (o_out)
    );

endmodule
`default_nettype wire

[rtl/cddc_regs.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cddc_regs
// APB register file holding the time and distance limits.
// ----------------------------------------------------------------------------
module cddc_regs
    import cddc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [CFG_W-1:0]  pwdata,
    output logic      [CFG_W-1:0]  prdata,
    output logic                   pready,
    output t_cfg                   o_cfg
);

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx reg_idx;
    logic     wr_en;

    assign reg_idx = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            case (reg_idx)
                REG_HOLD_LIMIT: n_cfg.hold_limit_us = pwdata;
                REG_GAP_LIMIT:  n_cfg.gap_limit_us  = pwdata;
                REG_DRAG_DIST:  n_cfg.drag_dist_sq  = pwdata;
                REG_GAP_DIST:   n_cfg.gap_dist_sq   = pwdata;
                default:        n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_HOLD_LIMIT: prdata = r_cfg.hold_limit_us;
            REG_GAP_LIMIT:  prdata = r_cfg.gap_limit_us;
            REG_DRAG_DIST:  prdata = r_cfg.drag_dist_sq;
            REG_GAP_DIST:   prdata = r_cfg.gap_dist_sq;
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hold_limit_us <= HOLD_LIMIT_RST;
            r_cfg.gap_limit_us  <= GAP_LIMIT_RST;
            r_cfg.drag_dist_sq  <= DRAG_DIST_RST;
            r_cfg.gap_dist_sq   <= GAP_DIST_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule
`default_nettype wire

[rtl/cddc_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cddc_front
// Input register stage: captures a tick and forms the pointer move against
// the position of the previously accepted tick.
// ----------------------------------------------------------------------------
module cddc_front
    import cddc_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    cddc_in_if.sink    i_in,
    input  wire logic  i_take,
    output logic       o_valid,
    output t_tick      o_tick
);

    logic                    r_valid;
    t_tick                   r_tick;
    t_tick                   n_tick;
    logic signed [POS_W-1:0] r_prev_x;
    logic signed [POS_W-1:0] r_prev_y;
    logic                    accept;

    assign i_in.ready = !r_valid || i_take;
    assign accept     = i_in.valid && i_in.ready;
    assign o_valid    = r_valid;
    assign o_tick     = r_tick;

    always_comb begin
        n_tick.elapsed_us  = i_in.elapsed_us;
        n_tick.button_down = i_in.button_down;
        n_tick.move_x      = {i_in.pointer_x[POS_W-1], i_in.pointer_x}
                           - {r_prev_x[POS_W-1], r_prev_x};
        n_tick.move_y      = {i_in.pointer_y[POS_W-1], i_in.pointer_y}
                           - {r_prev_y[POS_W-1], r_prev_y};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_prev_x <= '0;
            r_prev_y <= '0;
        end else begin
            if (accept) begin
                r_valid  <= 1'b1;
                r_prev_x <= i_in.pointer_x;
                r_prev_y <= i_in.pointer_y;
            end else if (i_take) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_tick <= n_tick;
        end
    end

endmodule
`default_nettype wire

[rtl/cddc_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cddc_core
// Gesture state machine with phase timer, travel accumulation and the
// result register.
// ----------------------------------------------------------------------------
module cddc_core
    import cddc_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    input  wire t_tick i_tick,
    input  wire t_cfg  i_cfg,
    output logic       o_take,
    cddc_out_if.source o_out
);

    localparam logic signed [TRAVEL_W-1:0] TRAVEL_MAX = {1'b0, {(TRAVEL_W-1){1'b1}}};
    localparam logic signed [TRAVEL_W-1:0] TRAVEL_MIN = {1'b1, {(TRAVEL_W-1){1'b0}}};

    t_phase                     r_phase;
    t_phase                     n_phase;
    t_gesture                   r_gesture;
    t_gesture                   n_gesture;
    logic [TIMER_W-1:0]         r_timer;
    logic [TIMER_W-1:0]         n_timer;
    logic signed [TRAVEL_W-1:0] r_travel_x;
    logic signed [TRAVEL_W-1:0] r_travel_y;
    logic signed [TRAVEL_W-1:0] n_travel_x;
    logic signed [TRAVEL_W-1:0] n_travel_y;

    logic                       r_out_valid;
    t_gesture                   r_out_gesture;
    logic signed [MOVE_W-1:0]   r_out_move_x;
    logic signed [MOVE_W-1:0]   r_out_move_y;

    logic [TIMER_W:0]           timer_sum;
    logic [TIMER_W-1:0]         timer_acc;
    logic signed [TRAVEL_W:0]   tx_sum;
    logic signed [TRAVEL_W:0]   ty_sum;
    logic signed [TRAVEL_W-1:0] tx_acc;
    logic signed [TRAVEL_W-1:0] ty_acc;
    logic signed [SQ_W-1:0]     sq_x;
    logic signed [SQ_W-1:0]     sq_y;
    logic [SQ_W-1:0]            offset;
    logic                       drag_hit;
    logic                       gap_hit;
    logic                       enter;

    assign o_take = i_valid && (!r_out_valid || o_out.ready);

    // Saturating timer and travel updates for this tick.
    always_comb begin
        timer_sum = {1'b0, r_timer} + {{(TIMER_W+1-DT_W){1'b0}}, i_tick.elapsed_us};
        timer_acc = timer_sum[TIMER_W] ? {TIMER_W{1'b1}} : timer_sum[TIMER_W-1:0];

        tx_sum = {r_travel_x[TRAVEL_W-1], r_travel_x}
               + {{(TRAVEL_W+1-MOVE_W){i_tick.move_x[MOVE_W-1]}}, i_tick.move_x};
        ty_sum = {r_travel_y[TRAVEL_W-1], r_travel_y}
               + {{(TRAVEL_W+1-MOVE_W){i_tick.move_y[MOVE_W-1]}}, i_tick.move_y};

        if (tx_sum[TRAVEL_W] != tx_sum[TRAVEL_W-1]) begin
            tx_acc = tx_sum[TRAVEL_W] ? TRAVEL_MIN : TRAVEL_MAX;
        end else begin
            tx_acc = tx_sum[TRAVEL_W-1:0];
        end
        if (ty_sum[TRAVEL_W] != ty_sum[TRAVEL_W-1]) begin
            ty_acc = ty_sum[TRAVEL_W] ? TRAVEL_MIN : TRAVEL_MAX;
        end else begin
            ty_acc = ty_sum[TRAVEL_W-1:0];
        end
    end

    assign sq_x   = tx_acc * tx_acc;
    assign sq_y   = ty_acc * ty_acc;
    assign offset = SQ_W'(unsigned'(sq_x)) + SQ_W'(unsigned'(sq_y));

    assign drag_hit = (timer_acc > i_cfg.hold_limit_us)
                   || (offset > {{(SQ_W-CFG_W){1'b0}}, i_cfg.drag_dist_sq});
    assign gap_hit  = (timer_acc > i_cfg.gap_limit_us)
                   || (offset > {{(SQ_W-CFG_W){1'b0}}, i_cfg.gap_dist_sq});

    always_comb begin
        n_phase   = r_phase;
        n_gesture = r_gesture;
        enter     = 1'b0;
        case (r_phase)
            PH_FIRST_DOWN: begin
                if (!i_tick.button_down) begin
                    n_phase = PH_FIRST_UP;
                    enter   = 1'b1;
                end else if (drag_hit) begin
                    n_gesture = G_DRAG;
                    n_phase   = PH_END;
                end
            end
            PH_FIRST_UP: begin
                if (i_tick.button_down) begin
                    n_phase = PH_SECOND_DOWN;
                    enter   = 1'b1;
                end else if (gap_hit) begin
                    n_gesture = G_CLICK;
                    n_phase   = PH_START;
                end
            end
            PH_SECOND_DOWN: begin
                if (!i_tick.button_down) begin
                    n_phase = PH_SECOND_UP;
                    enter   = 1'b1;
                end else if (drag_hit) begin
                    n_gesture = G_DRAG;
                    n_phase   = PH_END;
                end
            end
            PH_SECOND_UP: begin
                n_gesture = G_DOUBLE;
                n_phase   = PH_START;
            end
            PH_END: begin
                if (!i_tick.button_down) begin
                    n_gesture = G_NONE;
                    n_phase   = PH_START;
                end
            end
            default: begin
                if (i_tick.button_down) begin
                    n_phase = PH_FIRST_DOWN;
                    enter   = 1'b1;
                end else begin
                    n_phase = PH_START;
                end
                n_gesture = G_NONE;
            end
        endcase

        // A new down or up phase starts with a clear timer and travel.
        n_timer    = enter ? '0 : timer_acc;
        n_travel_x = enter ? '0 : tx_acc;
        n_travel_y = enter ? '0 : ty_acc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_START;
            r_gesture   <= G_NONE;
            r_timer     <= '0;
            r_travel_x  <= '0;
            r_travel_y  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_take) begin
                r_phase     <= n_phase;
                r_gesture   <= n_gesture;
                r_timer     <= n_timer;
                r_travel_x  <= n_travel_x;
                r_travel_y  <= n_travel_y;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_out_gesture <= n_gesture;
            r_out_move_x  <= i_tick.move_x;
            r_out_move_y  <= i_tick.move_y;
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.gesture = r_out_gesture;
    assign o_out.move_x  = r_out_move_x;
    assign o_out.move_y  = r_out_move_y;

endmodule
`default_nettype wire

[rtl/cddc_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cddc_checker
// Port-level checks on the gesture sequence and the output handshake.
// ----------------------------------------------------------------------------
module cddc_checker
    import cddc_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_out_valid,
    input wire logic               i_out_ready,
    input wire logic [1:0]         i_gesture,
    input wire logic signed [16:0] i_move_x,
    input wire logic signed [16:0] i_move_y
);

    logic     out_acc;
    logic     r_seen;
    t_gesture r_prev_gesture;

    assign out_acc = i_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen         <= 1'b0;
            r_prev_gesture <= G_NONE;
        end else if (out_acc) begin
            r_seen         <= 1'b1;
            r_prev_gesture <= t_gesture'(i_gesture);
        end
    end

    // A stalled result holds until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_gesture)
            && $stable(i_move_x) && $stable(i_move_y))
        else $error("output item changed while stalled");

    // Click and double click last exactly one item.
    a_pulse_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && r_seen && (r_prev_gesture == G_CLICK || r_prev_gesture == G_DOUBLE)
            |-> i_gesture == G_NONE)
        else $error("click or double click reported on consecutive items");

    // A drag ends only by returning to none.
    a_drag_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && r_seen && r_prev_gesture == G_DRAG
            |-> i_gesture == G_DRAG || i_gesture == G_NONE)
        else $error("drag followed by click or double click");

    // Nothing is presented right after reset.
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("output valid directly after reset");

endmodule

bind click_doubleclick_drag_classifier cddc_checker u_cddc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_gesture   (o_out.gesture),
    .i_move_x    (o_out.move_x),
    .i_move_y    (o_out.move_y)
);
`default_nettype wire

[test/cddc_gesture_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gesture checker for the click, double-click and drag classifier
// Watches the tick and result channels and the register port. Every accepted
// tick runs through a local copy of the gesture machine. Each result that
// comes back is checked field by field against the oldest predicted result.
// ----------------------------------------------------------------------------
module cddc_gesture_checker
    import cddc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    cddc_in_if                     i_ticks,
    cddc_out_if                    i_results,
    input  wire logic              i_psel,
    input  wire logic              i_penable,
    input  wire logic              i_pwrite,
    input  wire logic              i_pready,
    input  wire logic [ADDR_W-1:0] i_paddr,
    input  wire logic [CFG_W-1:0]  i_pwdata,
    output int                     o_fail_count,
    output int                     o_pending,
    output int                     o_results,
    output int                     o_clicks,
    output int                     o_doubles,
    output int                     o_drags
);

    localparam int TRAVEL_HI = 131071;
    localparam int TRAVEL_LO = -131072;

    typedef struct packed {
        t_gesture                 gesture;
        logic signed [MOVE_W-1:0] move_x;
        logic signed [MOVE_W-1:0] move_y;
    } t_tick_result;

    t_cfg                       limits;
    t_phase                     gest_phase;
    t_gesture                   held_gesture;
    logic [TIMER_W-1:0]         phase_time;
    logic signed [POS_W-1:0]    last_x;
    logic signed [POS_W-1:0]    last_y;
    logic signed [TRAVEL_W-1:0] trav_x;
    logic signed [TRAVEL_W-1:0] trav_y;
    t_tick_result               expected_ticks[$];

    // Entering a down or up phase restarts the timer and the travel.
    function automatic void restart_phase(t_phase next);
        gest_phase = next;
        phase_time = '0;
        trav_x     = '0;
        trav_y     = '0;
    endfunction

    function automatic int clamp_travel(int v);
        if (v > TRAVEL_HI) return TRAVEL_HI;
        if (v < TRAVEL_LO) return TRAVEL_LO;
        return v;
    endfunction

    function automatic t_tick_result classify_tick(logic [DT_W-1:0] dt, logic down,
                                                   logic signed [POS_W-1:0] px,
                                                   logic signed [POS_W-1:0] py);
        longint unsigned time_sum;
        longint unsigned offset;
        int              dx;
        int              dy;
        int              tx;
        int              ty;
        logic            press_over;
        logic            gap_over;
        t_tick_result    r;

        time_sum   = longint'(phase_time) + longint'(dt);
        phase_time = (time_sum > 64'hFFFF_FFFF) ? '1 : time_sum[TIMER_W-1:0];

        dx = int'(px) - int'(last_x);
        dy = int'(py) - int'(last_y);
        tx = clamp_travel(int'(trav_x) + dx);
        ty = clamp_travel(int'(trav_y) + dy);
        trav_x = tx[TRAVEL_W-1:0];
        trav_y = ty[TRAVEL_W-1:0];
        last_x = px;
        last_y = py;

        // The squared travel can exceed 32 bits, so it is compared in 64.
        offset = longint'(tx) * longint'(tx) + longint'(ty) * longint'(ty);
        press_over = (phase_time > limits.hold_limit_us) ||
                     (offset > longint'(limits.drag_dist_sq));
        gap_over   = (phase_time > limits.gap_limit_us) ||
                     (offset > longint'(limits.gap_dist_sq));

        case (gest_phase)
            PH_FIRST_DOWN: begin
                if (!down) begin
                    restart_phase(PH_FIRST_UP);
                end else if (press_over) begin
                    held_gesture = G_DRAG;
                    gest_phase   = PH_END;
                end
            end
            PH_FIRST_UP: begin
                if (down) begin
                    restart_phase(PH_SECOND_DOWN);
                end else if (gap_over) begin
                    held_gesture = G_CLICK;
                    gest_phase   = PH_START;
                end
            end
            PH_SECOND_DOWN: begin
                if (!down) begin
                    restart_phase(PH_SECOND_UP);
                end else if (press_over) begin
                    held_gesture = G_DRAG;
                    gest_phase   = PH_END;
                end
            end
            PH_SECOND_UP: begin
                held_gesture = G_DOUBLE;
                gest_phase   = PH_START;
            end
            PH_END: begin
                if (!down) begin
                    held_gesture = G_NONE;
                    gest_phase   = PH_START;
                end
            end
            default: begin
                if (down) begin
                    restart_phase(PH_FIRST_DOWN);
                end else begin
                    gest_phase = PH_START;
                end
                held_gesture = G_NONE;
            end
        endcase

        r.gesture = held_gesture;
        r.move_x  = dx[MOVE_W-1:0];
        r.move_y  = dy[MOVE_W-1:0];
        return r;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_tick_result seen;
        t_tick_result want;

        if (!i_rst_n) begin
            limits.hold_limit_us = HOLD_LIMIT_RST;
            limits.gap_limit_us  = GAP_LIMIT_RST;
            limits.drag_dist_sq  = DRAG_DIST_RST;
            limits.gap_dist_sq   = GAP_DIST_RST;
            gest_phase   = PH_START;
            held_gesture = G_NONE;
            phase_time   = '0;
            last_x       = '0;
            last_y       = '0;
            trav_x       = '0;
            trav_y       = '0;
            expected_ticks.delete();
            o_fail_count = 0;
            o_results    = 0;
            o_clicks     = 0;
            o_doubles    = 0;
            o_drags      = 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg_idx'(i_paddr[3:2]))
                    REG_HOLD_LIMIT: limits.hold_limit_us = i_pwdata;
                    REG_GAP_LIMIT:  limits.gap_limit_us  = i_pwdata;
                    REG_DRAG_DIST:  limits.drag_dist_sq  = i_pwdata;
                    REG_GAP_DIST:   limits.gap_dist_sq   = i_pwdata;
                    default: ;
                endcase
            end

            if (i_results.valid && i_results.ready) begin
                seen.gesture = t_gesture'(i_results.gesture);
                seen.move_x  = i_results.move_x;
                seen.move_y  = i_results.move_y;
                o_results++;
                if (seen.gesture == G_CLICK)  o_clicks++;
                if (seen.gesture == G_DOUBLE) o_doubles++;
                if (seen.gesture == G_DRAG)   o_drags++;
                if (expected_ticks.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("%0t: result with no tick waiting: gesture %0d move (%0d,%0d)",
                                 $realtime, seen.gesture, seen.move_x, seen.move_y);
                    o_fail_count++;
                end else begin
                    want = expected_ticks.pop_front();
                    if (seen.gesture !== want.gesture || seen.move_x !== want.move_x ||
                        seen.move_y !== want.move_y) begin
                        if (o_fail_count < 10)
                            $display("%0t: result %0d: expected %0d (%0d,%0d), got %0d (%0d,%0d)",
                                     $realtime, o_results, want.gesture, want.move_x,
                                     want.move_y, seen.gesture, seen.move_x, seen.move_y);
                        o_fail_count++;
                    end
                end
            end

            if (i_ticks.valid && i_ticks.ready)
                expected_ticks.insert(expected_ticks.size(),
                                      classify_tick(i_ticks.elapsed_us,
                                                    i_ticks.button_down,
                                                    i_ticks.pointer_x,
                                                    i_ticks.pointer_y));
        end
        o_pending = expected_ticks.size();
    end

endmodule

[test/tb_click_doubleclick_drag_classifier.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the click, double-click and drag classifier
// Drives pointer ticks through directed gestures and long runs of random
// gestures under default, zero, near-maximum and random limits, with random
// gaps on both channels, a long output hold-off and a run of large time steps.
// The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_click_doubleclick_drag_classifier
    import cddc_pkg::*;
();

    localparam int STALL_LIMIT   = 2000;
    localparam int LONG_HOLD_OFF = 300;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [CFG_W-1:0]  pwdata;
    logic [CFG_W-1:0]  prdata;
    logic              pready;

    int fail_count;
    int pending;
    int result_count;
    int click_count;
    int double_count;
    int drag_count;
    int ticks_sent;
    int hold_offs;
    int settings_used;
    bit burst_mode;
    bit hold_off_req;

    logic signed [POS_W-1:0] cur_x;
    logic signed [POS_W-1:0] cur_y;

    cddc_in_if  tick_ch ();
    cddc_out_if result_ch ();

    click_doubleclick_drag_classifier dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (tick_ch),
        .o_out   (result_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    cddc_gesture_checker gesture_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ticks      (tick_ch),
        .i_results    (result_ch),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_results    (result_count),
        .o_clicks     (click_count),
        .o_doubles    (double_count),
        .o_drags      (drag_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Takes one item at a time after a random stall, or holds off for a long
    // stretch when asked so that the block backs up into its input.
    initial begin : result_sink
        int stall;

        result_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            stall = burst_mode ? 0 : $urandom_range(0, 10);
            if (hold_off_req) begin
                stall        = LONG_HOLD_OFF;
                hold_off_req = 1'b0;
                hold_offs++;
            end
            if (stall > 0) begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!result_ch.valid);
        end
    end

    initial begin : watchdog
        int quiet;

        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((tick_ch.valid && tick_ch.ready) || (result_ch.valid && result_ch.ready) ||
                (psel && penable))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: nothing moved for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, pending);
        $display("tb_click_doubleclick_drag_classifier: errors");
        $finish;
    end

    task automatic send_tick(logic [DT_W-1:0] dt, logic down,
                             logic signed [POS_W-1:0] px, logic signed [POS_W-1:0] py);
        int gap;

        gap = burst_mode ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            tick_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        tick_ch.valid       <= 1'b1;
        tick_ch.elapsed_us  <= dt;
        tick_ch.button_down <= down;
        tick_ch.pointer_x   <= px;
        tick_ch.pointer_y   <= py;
        do @(posedge i_clk); while (!tick_ch.ready);
        ticks_sent++;
    endtask

    // Stops offering ticks and waits until every predicted result is back.
    task automatic wait_for_results();
        tick_ch.valid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic put_reg(t_reg_idx idx, logic [CFG_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
    endtask

    task automatic load_limits(t_cfg lim);
        put_reg(REG_HOLD_LIMIT, lim.hold_limit_us);
        put_reg(REG_GAP_LIMIT, lim.gap_limit_us);
        put_reg(REG_DRAG_DIST, lim.drag_dist_sq);
        put_reg(REG_GAP_DIST, lim.gap_dist_sq);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        settings_used++;
    endtask

    // Mostly short steps so that gestures survive the time limits.
    function automatic logic [DT_W-1:0] rand_dt();
        int pick;

        pick = $urandom_range(0, 9);
        if (pick <= 5) return DT_W'($urandom_range(0, 40000));
        if (pick <= 8) return DT_W'($urandom_range(0, 300000));
        return DT_W'($urandom_range(0, 1048575));
    endfunction

    function automatic void move_pointer();
        int pick;

        pick = $urandom_range(0, 29);
        if (pick == 0) begin
            cur_x = POS_W'($urandom);
            cur_y = POS_W'($urandom);
        end else if (pick <= 16) begin
            cur_x = cur_x + POS_W'($urandom_range(0, 2)) - 16'sd1;
            cur_y = cur_y + POS_W'($urandom_range(0, 2)) - 16'sd1;
        end
    endfunction

    // One press pattern with random timing and motion: clicks, double
    // clicks, long holds, a broken double press, or plain noise.
    task automatic gesture_burst();
        int   kind;
        int   segs;
        int   len;
        logic level;

        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            repeat ($urandom_range(1, 6)) begin
                move_pointer();
                send_tick(rand_dt(), 1'($urandom_range(0, 1)), cur_x, cur_y);
            end
        end else begin
            segs  = (kind <= 3) ? 2 : (kind <= 6) ? 4 : (kind <= 8) ? 2 : 3;
            level = 1'b1;
            for (int s = 0; s < segs; s++) begin
                len = (kind >= 7 && kind <= 8 && s == 0) ? $urandom_range(2, 12)
                                                         : $urandom_range(1, 3);
                repeat (len) begin
                    move_pointer();
                    send_tick(rand_dt(), level, cur_x, cur_y);
                end
                level = ~level;
            end
            repeat ($urandom_range(1, 4)) begin
                move_pointer();
                send_tick(rand_dt(), 1'b0, cur_x, cur_y);
            end
        end
        if ($urandom_range(0, 7) == 0) burst_mode = ~burst_mode;
    endtask

    task automatic run_gestures(int count);
        int first;

        first = ticks_sent;
        while (ticks_sent - first < count) gesture_burst();
    endtask

    function automatic t_cfg random_limits();
        t_cfg lim;

        lim.hold_limit_us = $urandom_range(0, 500000);
        lim.gap_limit_us  = $urandom_range(0, 300000);
        lim.drag_dist_sq  = $urandom_range(0, 40);
        lim.gap_dist_sq   = $urandom_range(0, 8);
        return lim;
    endfunction

    initial begin : stimulus
        t_cfg lim;

        i_rst_n             <= 1'b0;
        tick_ch.valid       <= 1'b0;
        tick_ch.elapsed_us  <= '0;
        tick_ch.button_down <= 1'b0;
        tick_ch.pointer_x   <= '0;
        tick_ch.pointer_y   <= '0;
        psel                <= 1'b0;
        penable             <= 1'b0;
        pwrite              <= 1'b0;
        paddr               <= '0;
        pwdata              <= '0;
        cur_x = '0;
        cur_y = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Default limits. The first move is measured from the origin.
        send_tick(20'd0, 1'b0, -16'sd32768, 16'sd32767);
        send_tick(20'hFFFFF, 1'b0, 16'sd32767, -16'sd32768);
        // Click after the release wait; a wait equal to the limit is not enough.
        send_tick(20'd1000, 1'b1, 16'sd0, 16'sd0);
        send_tick(20'd1000, 1'b0, 16'sd0, 16'sd0);
        send_tick(20'd100000, 1'b0, 16'sd0, 16'sd0);
        send_tick(20'd1, 1'b0, 16'sd0, 16'sd0);
        // Double click, reported on the tick after the second release.
        send_tick(20'd1000, 1'b1, 16'sd0, 16'sd0);
        send_tick(20'd1000, 1'b0, 16'sd0, 16'sd0);
        send_tick(20'd1000, 1'b1, 16'sd0, 16'sd0);
        send_tick(20'd1000, 1'b0, 16'sd0, 16'sd0);
        send_tick(20'd1000, 1'b0, 16'sd0, 16'sd0);
        // Drag by holding: exactly the limit, then one microsecond more.
        send_tick(20'd0, 1'b1, 16'sd0, 16'sd0);
        send_tick(20'd200000, 1'b1, 16'sd0, 16'sd0);
        send_tick(20'd1, 1'b1, 16'sd0, 16'sd0);
        send_tick(20'd0, 1'b0, 16'sd0, 16'sd0);
        // Drag by distance: squared travel of 9 holds, 10 starts the drag.
        send_tick(20'd0, 1'b1, 16'sd0, 16'sd0);
        send_tick(20'd0, 1'b1, 16'sd3, 16'sd0);
        send_tick(20'd0, 1'b1, 16'sd3, 16'sd1);
        send_tick(20'd0, 1'b0, 16'sd3, 16'sd1);
        // A second press held too long turns into a drag.
        send_tick(20'd0, 1'b1, 16'sd3, 16'sd1);
        send_tick(20'd0, 1'b0, 16'sd3, 16'sd1);
        send_tick(20'd0, 1'b1, 16'sd3, 16'sd1);
        send_tick(20'hFFFFF, 1'b1, 16'sd3, 16'sd1);
        send_tick(20'd0, 1'b0, 16'sd3, 16'sd1);
        // Motion after release ends the wait with a click.
        send_tick(20'd0, 1'b1, 16'sd3, 16'sd1);
        send_tick(20'd0, 1'b0, 16'sd3, 16'sd1);
        send_tick(20'd0, 1'b0, 16'sd4, 16'sd1);
        send_tick(20'd0, 1'b0, 16'sd5, 16'sd1);
        cur_x = 16'sd5;
        cur_y = 16'sd1;

        // The receiver stalls for a long stretch while ticks keep coming.
        hold_off_req = 1'b1;
        run_gestures(300);
        wait_for_results();

        lim = '{hold_limit_us: '0, gap_limit_us: '0, drag_dist_sq: '0, gap_dist_sq: '0};
        load_limits(lim);
        run_gestures(200);
        // Released ticks with time passing bring the machine back to start.
        repeat (3) send_tick(20'd1, 1'b0, cur_x, cur_y);
        wait_for_results();

        lim = '{hold_limit_us: 32'hFFFF_FFFE, gap_limit_us: '1, drag_dist_sq: '1,
                gap_dist_sq: '1};
        load_limits(lim);
        // With limits near their maximum, a press built from the largest time
        // steps stays a press, since the timer stays far below the hold limit.
        burst_mode = 1'b1;
        send_tick(20'd0, 1'b1, cur_x, cur_y);
        repeat (40) send_tick(20'hFFFFF, 1'b1, cur_x, cur_y);
        send_tick(20'd0, 1'b0, cur_x, cur_y);
        // Full-span jump while pressed: squared travel beyond 32 bits.
        send_tick(20'd0, 1'b0, -16'sd32768, -16'sd32768);
        send_tick(20'd0, 1'b1, -16'sd32768, -16'sd32768);
        send_tick(20'd0, 1'b1, 16'sd32767, 16'sd32767);
        send_tick(20'd0, 1'b0, 16'sd32767, 16'sd32767);
        cur_x = 16'sd32767;
        cur_y = 16'sd32767;
        burst_mode = 1'b0;
        run_gestures(150);
        wait_for_results();

        load_limits(random_limits());
        run_gestures(175);
        wait_for_results();
        run_gestures(175);
        wait_for_results();

        load_limits(random_limits());
        run_gestures(275);
        wait_for_results();

        $display("Sent %0d ticks under %0d limit settings plus defaults, %0d long hold-off(s).",
                 ticks_sent, settings_used, hold_offs);
        $display("Checked %0d results: %0d clicks, %0d double clicks, %0d drag ticks.",
                 result_count, click_count, double_count, drag_count);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_click_doubleclick_drag_classifier: clean");
        end else begin
            $display("tb_click_doubleclick_drag_classifier: errors");
        end
        $finish;
    end

endmodule
